/* hw/rtl/toeq_pkg.sv */
// shared types and constants for the time ordered event queue
// no dependencies; used by toeq_cell and time_ordered_event_queue
package toeq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;
  localparam int DATA_W          = 32;
  localparam int CNT_OUT_W       = 5;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } op_err_t;

  typedef struct packed {
    logic              func;
    logic              event_kind;
    logic              service_area;
    logic [DATA_W-1:0] carried_delay;
    logic [DATA_W-1:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic                 head_valid;
    logic                 head_kind;
    logic                 head_area;
    logic [DATA_W-1:0]    head_delay;
    logic [DATA_W-1:0]    head_time;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [1:0]           op_error;
  } out_item_t;

  // payload carried by one cell besides its time key
  typedef struct packed {
    logic              kind;
    logic              area;
    logic [DATA_W-1:0] delay;
  } cell_data_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } toeq_ctl_t;

endpackage

/* hw/rtl/toeq_cell.sv */
// one slot of the sorted event chain: compare against the new key, shift left or right
// depends on toeq_pkg
module toeq_cell
  import toeq_pkg::*;
#(
  parameter int KEY_W = TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  toeq_ctl_t        ctl,
  input  cell_data_t       new_data,
  input  logic [KEY_W-1:0] new_key,
  input  logic             left_valid,
  input  logic             left_ge,
  input  cell_data_t       left_data,
  input  logic [KEY_W-1:0] left_key,
  input  logic             right_valid,
  input  cell_data_t       right_data,
  input  logic [KEY_W-1:0] right_key,
  output logic             valid,
  output logic             ge,
  output cell_data_t       data,
  output logic [KEY_W-1:0] key
);

  logic             valid_r, valid_nxt;
  cell_data_t       data_r, data_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;

  // new entry goes at or before this slot
  assign ge = !valid_r || (key_r > new_key);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    key_nxt   = key_r;
    if (ctl.ins) begin
      if (left_ge) begin
        valid_nxt = left_valid;
        data_nxt  = left_data;
        key_nxt   = left_key;
      end else if (ge) begin
        valid_nxt = 1'b1;
        data_nxt  = new_data;
        key_nxt   = new_key;
      end
    end else if (ctl.rem) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
      key_nxt   = right_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    key_r  <= key_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;
  assign key   = key_r;

endmodule

/* hw/rtl/time_ordered_event_queue.sv */
// top level of the time ordered event queue: chain of sorting cells plus result register
// depends on toeq_pkg and toeq_cell
//
// Event queue kept sorted by event time, earliest first. An insert transaction (func 0)
// places the event after every stored entry with an equal or smaller time, so equal times
// leave in arrival order; a remove transaction (func 1) drops the earliest entry. Every
// transaction gives one result holding the head entry (all zero when the queue is empty),
// the entry count and an error code: insert into a full queue and remove from an empty
// queue leave the queue untouched and are flagged. Storage is a row of QUEUE_DEPTH
// identical cells; each cell compares its key with the incoming time in parallel and
// takes its left or right neighbor's entry in the same cycle, so one transaction is
// accepted per clock cycle unless in_stall is high. The result is registered and shows
// in the cycle after the input is accepted; the input is stalled only while a result
// waits under out_stall. Times are compared on their low TIME_BITS bits (at most 32).
// Stored entries need no clearing after reset, so input is accepted right out of reset.
module time_ordered_event_queue
  import toeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int KEY_W = (TIME_BITS < DATA_W) ? TIME_BITS : DATA_W;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // cell chain taps
  logic [QUEUE_DEPTH-1:0] valid_v;
  logic [QUEUE_DEPTH-1:0] ge_v;
  cell_data_t             data_a [QUEUE_DEPTH];
  logic [KEY_W-1:0]       key_a  [QUEUE_DEPTH];

  toeq_ctl_t        ctl;
  cell_data_t       new_data;
  logic [KEY_W-1:0] new_key;

  logic       accept;
  logic       is_rem;
  logic       full;
  logic       empty;

  logic [CNT_W-1:0] count_r, count_nxt;
  op_err_t          err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;

  // handshake: hold input only while a finished result is not taken
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_rem = (in_data.func == FUNC_REMOVE);
  assign full   = valid_v[QUEUE_DEPTH-1];
  assign empty  = !valid_v[0];

  assign ctl.ins = accept && !is_rem && !full;
  assign ctl.rem = accept && is_rem && !empty;

  assign new_data.kind  = in_data.event_kind;
  assign new_data.area  = in_data.service_area;
  assign new_data.delay = in_data.carried_delay;
  assign new_key        = in_data.event_time[KEY_W-1:0];

  // row of cells, cell 0 holds the earliest event
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             l_valid, l_ge, r_valid;
    cell_data_t       l_data, r_data;
    logic [KEY_W-1:0] l_key, r_key;

    if (i == 0) begin : g_first
      assign l_valid = 1'b0;
      assign l_ge    = 1'b0;
      assign l_data  = '0;
      assign l_key   = '0;
    end else begin : g_mid_l
      assign l_valid = valid_v[i-1];
      assign l_ge    = ge_v[i-1];
      assign l_data  = data_a[i-1];
      assign l_key   = key_a[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      // the end of the chain shifts in an empty slot on remove
      assign r_valid = 1'b0;
      assign r_data  = '0;
      assign r_key   = '0;
    end else begin : g_mid_r
      assign r_valid = valid_v[i+1];
      assign r_data  = data_a[i+1];
      assign r_key   = key_a[i+1];
    end

    toeq_cell #(
      .KEY_W (KEY_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_data    (new_data),
      .new_key     (new_key),
      .left_valid  (l_valid),
      .left_ge     (l_ge),
      .left_data   (l_data),
      .left_key    (l_key),
      .right_valid (r_valid),
      .right_data  (r_data),
      .right_key   (r_key),
      .valid       (valid_v[i]),
      .ge          (ge_v[i]),
      .data        (data_a[i]),
      .key         (key_a[i])
    );
  end

  // count and error code for the result
  always_comb begin
    count_nxt = count_r;
    err_nxt   = err_r;
    if (accept) begin
      err_nxt = ERR_NONE;
      if (ctl.ins) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (ctl.rem) begin
        count_nxt = count_r - CNT_W'(1);
      end else if (is_rem) begin
        err_nxt = ERR_EMPTY;
      end else begin
        err_nxt = ERR_FULL;
      end
    end
  end

  // result register: loaded on accept, cleared once taken
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // head fields come straight from cell 0, which holds still while the result waits
  assign out_valid            = out_valid_r;
  assign out_data.head_valid  = valid_v[0];
  assign out_data.head_kind   = valid_v[0] ? data_a[0].kind : 1'b0;
  assign out_data.head_area   = valid_v[0] ? data_a[0].area : 1'b0;
  assign out_data.head_delay  = valid_v[0] ? data_a[0].delay : '0;
  assign out_data.head_time   = valid_v[0] ? DATA_W'(key_a[0]) : '0;
  assign out_data.entry_count = CNT_OUT_W'(count_r);
  assign out_data.op_error    = err_r;

`ifndef NO_ASSERTIONS
  // occupied cells form a prefix whose length is the count
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_v) == 32'(count_r))
    else $error("cell occupancy differs from entry count");

  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_v[QUEUE_DEPTH-1:1] & ~valid_v[QUEUE_DEPTH-2:0]) == '0)
    else $error("occupied cells are not contiguous from the head");

  // head never later than its neighbor
  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    valid_v[1] |-> (key_a[0] <= key_a[1]))
    else $error("head entry out of time order");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("accepted insert did not grow the queue");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && err_r == ERR_FULL) |-> (count_r == CNT_W'(QUEUE_DEPTH)))
    else $error("full error reported on a queue that is not full");
`endif

endmodule
